FILE: hdl/sliding_median_deviation_top_defines.svh
// Assertion macros for the sliding median deviation block
`ifndef SLIDING_MEDIAN_DEVIATION_TOP_DEFINES_SVH
`define SLIDING_MEDIAN_DEVIATION_TOP_DEFINES_SVH

// same-cycle implication, clocked on i_clk, off while i_rst_n is low
`define SMD_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("smd: same-cycle check failed");

// next-cycle implication
`define SMD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("smd: next-cycle check failed");

`endif

FILE: hdl/smd_pkg.sv
// Shared constants for the sliding median deviation block
`default_nettype none

package smd_pkg;

    // heap selector: lower half is a max-heap, upper half a min-heap
    localparam logic SIDE_LOWER = 1'b0;
    localparam logic SIDE_UPPER = 1'b1;

endpackage

`default_nettype wire

FILE: hdl/smd_store.sv
// Heap and slot-position memories for the sliding median deviation block
`default_nettype none

module smd_store #(
    parameter int WMAX = 256,
    parameter int SB   = 20
) (
    input  wire logic                         i_clk,
    // heap memory: entry = {sample, slot}, address = {side, index}
    input  wire logic                         i_h_we,
    input  wire logic [$clog2(WMAX+1):0]      i_h_waddr,
    input  wire logic [SB+$clog2(WMAX)-1:0]   i_h_wdata,
    input  wire logic [$clog2(WMAX+1):0]      i_h_raddr_a,
    input  wire logic [$clog2(WMAX+1):0]      i_h_raddr_b,
    output logic      [SB+$clog2(WMAX)-1:0]   o_h_rdata_a,
    output logic      [SB+$clog2(WMAX)-1:0]   o_h_rdata_b,
    // position memory: per slot {side, heap index}
    input  wire logic                         i_p_we,
    input  wire logic [$clog2(WMAX)-1:0]      i_p_waddr,
    input  wire logic [$clog2(WMAX+1):0]      i_p_wdata,
    input  wire logic [$clog2(WMAX)-1:0]      i_p_raddr,
    output logic      [$clog2(WMAX+1):0]      o_p_rdata
);

    localparam int SW = $clog2(WMAX);
    localparam int LW = $clog2(WMAX + 1);
    localparam int EW = SB + SW;
    localparam int HD = 2 ** (LW + 1);

    logic [EW-1:0] r_heap [HD];
    logic [LW:0]   r_pos  [WMAX];

    // heap memory, one write and two registered reads
    always_ff @(posedge i_clk) begin
        if (i_h_we) begin
            r_heap[i_h_waddr] <= i_h_wdata;
        end
        o_h_rdata_a <= r_heap[i_h_raddr_a];
        o_h_rdata_b <= r_heap[i_h_raddr_b];
    end

    // position memory, one write and one registered read
    always_ff @(posedge i_clk) begin
        if (i_p_we) begin
            r_pos[i_p_waddr] <= i_p_wdata;
        end
        o_p_rdata <= r_pos[i_p_raddr];
    end

endmodule

`default_nettype wire

FILE: hdl/sliding_median_deviation_top.sv
// Each heap level a sift passes takes a read, then a compare and write.
// One item at a time: the input is stalled until the sample is done, including
// any time the result waits on the output stall.
// Reset (synchronous, active low) empties the window and sets length to 1.
// Top level: sliding window lower median and sum of absolute deviations
`default_nettype none

module sliding_median_deviation_top #(
    parameter int WMAX = 256,
    parameter int SB   = 20
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // sample input
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic [SB-1:0]                  i_sample,
    // result output
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic      [SB-1:0]                  o_median,
    output logic      [SB+$clog2(WMAX)-1:0]     o_deviation_cost,
    // window length register
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [$clog2(WMAX+1)-1:0]      i_cfg_window_length
);

`include "sliding_median_deviation_top_defines.svh"

    localparam int SW = $clog2(WMAX);
    localparam int LW = $clog2(WMAX + 1);
    localparam int EW = SB + SW;
    localparam int TW = SB + SW;
    localparam int AW = LW + 1;

    localparam logic [4:0] ST_IDLE   = 5'd0;
    localparam logic [4:0] ST_INS    = 5'd1;
    localparam logic [4:0] ST_SU_RD  = 5'd2;
    localparam logic [4:0] ST_SU_CMP = 5'd3;
    localparam logic [4:0] ST_SU_END = 5'd4;
    localparam logic [4:0] ST_SD_RD  = 5'd5;
    localparam logic [4:0] ST_SD_CMP = 5'd6;
    localparam logic [4:0] ST_SD_END = 5'd7;
    localparam logic [4:0] ST_REB    = 5'd8;
    localparam logic [4:0] ST_RM_RD  = 5'd9;
    localparam logic [4:0] ST_RM_DO  = 5'd10;
    localparam logic [4:0] ST_RBPUSH = 5'd11;
    localparam logic [4:0] ST_RBEND  = 5'd12;
    localparam logic [4:0] ST_POST   = 5'd13;
    localparam logic [4:0] ST_OUT    = 5'd14;
    localparam logic [4:0] ST_RM_POS = 5'd15;
    localparam logic [4:0] ST_RM_PSW = 5'd16;

    localparam logic [LW-1:0] LEN_MAX = LW'(WMAX);
    localparam logic [SW-1:0] SLOT_LAST = SW'(WMAX - 1);

    // control state
    logic [4:0]    r_state, n_state, r_ret, n_ret;
    logic [LW-1:0] r_len, n_len, r_lcnt, n_lcnt, r_ucnt, n_ucnt, r_fill, n_fill;
    logic [TW-1:0] r_ltot, n_ltot, r_utot, n_utot;
    logic [SW-1:0] r_wslot, n_wslot;
    logic          r_out_valid, n_out_valid;
    // working registers
    logic [SW-1:0] r_slot, n_slot, r_oldest, n_oldest;
    logic [EW-1:0] r_ent, n_ent, r_rem, n_rem;
    logic [LW-1:0] r_idx, n_idx;
    logic          r_h, n_h, r_down, n_down, r_phase, n_phase;
    logic [SB-1:0] r_med, n_med;
    logic [TW-1:0] r_cost, n_cost;

    // memory port controls
    logic          h_we, p_we;
    logic [AW-1:0] h_waddr, h_ra, h_rb;
    logic [EW-1:0] h_wdata, h_rd_a, h_rd_b;
    logic [SW-1:0] p_waddr;
    logic [LW:0]   p_wdata, p_rd;

    // helpers
    logic [LW-1:0] len_eff, cnt_h, fill_inc;
    logic [LW:0]   kid_l, kid_r, old_diff;
    logic [EW-1:0] best_ent;
    logic [LW-1:0] best_idx;
    logic          best_moved;
    logic [SB-1:0] top_val;

    function automatic logic f_ahead(input logic h, input logic [SB-1:0] a,
                                     input logic [SB-1:0] b);
        f_ahead = (h == smd_pkg::SIDE_UPPER) ? (a < b) : (a > b);
    endfunction

    // clamp of the configured length
    always_comb begin
        if (r_len == '0) begin
            len_eff = LW'(1);
        end else if (r_len > LEN_MAX) begin
            len_eff = LEN_MAX;
        end else begin
            len_eff = r_len;
        end
    end

    assign cnt_h    = r_h ? r_ucnt : r_lcnt;
    assign kid_l    = {r_idx, 1'b0};
    assign kid_r    = {r_idx, 1'b1};
    assign fill_inc = r_fill + LW'(1);
    assign old_diff = {1'b0, LW'(r_slot)} - {1'b0, len_eff - LW'(1)};
    assign top_val  = h_rd_a[EW-1:SW];

    // pick the child that should move up in a sift-down step
    always_comb begin
        best_ent   = r_ent;
        best_idx   = r_idx;
        best_moved = 1'b0;
        if (kid_l <= {1'b0, cnt_h} && f_ahead(r_h, h_rd_a[EW-1:SW], best_ent[EW-1:SW])) begin
            best_ent   = h_rd_a;
            best_idx   = kid_l[LW-1:0];
            best_moved = 1'b1;
        end
        if (kid_r <= {1'b0, cnt_h} && f_ahead(r_h, h_rd_b[EW-1:SW], best_ent[EW-1:SW])) begin
            best_ent   = h_rd_b;
            best_idx   = kid_r[LW-1:0];
            best_moved = 1'b1;
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;  n_ret = r_ret;     n_len = r_len;
        n_lcnt = r_lcnt;    n_ucnt = r_ucnt;   n_fill = r_fill;
        n_ltot = r_ltot;    n_utot = r_utot;   n_wslot = r_wslot;
        n_slot = r_slot;    n_oldest = r_oldest;
        n_ent = r_ent;      n_rem = r_rem;     n_idx = r_idx;
        n_h = r_h;          n_down = r_down;   n_phase = r_phase;
        n_med = r_med;      n_cost = r_cost;
        n_out_valid = r_out_valid && i_out_stall;

        h_we = 1'b0;  h_waddr = {r_h, r_idx};  h_wdata = r_ent;
        h_ra = {smd_pkg::SIDE_LOWER, LW'(1)};  h_rb = h_ra;
        p_we = 1'b0;  p_waddr = r_ent[SW-1:0]; p_wdata = {r_h, r_idx};

        case (r_state)
            ST_IDLE: begin
                if (i_cfg_valid) begin
                    n_len = i_cfg_window_length;
                    n_lcnt = '0;  n_ucnt = '0;  n_ltot = '0;  n_utot = '0;
                    n_wslot = '0; n_fill = '0;
                end else if (i_in_valid) begin
                    n_slot  = r_wslot;
                    n_ent   = {i_sample, r_wslot};
                    n_state = ST_INS;
                end
            end
            // choose a half for the new sample and push it
            ST_INS: begin
                n_ret = ST_REB;  n_phase = 1'b0;  n_down = 1'b0;
                n_state = ST_SU_RD;
                if (r_lcnt == '0 || r_ent[EW-1:SW] <= top_val) begin
                    n_h = smd_pkg::SIDE_LOWER;
                    n_lcnt = r_lcnt + LW'(1);
                    n_ltot = r_ltot + TW'(r_ent[EW-1:SW]);
                    n_idx = r_lcnt + LW'(1);
                end else begin
                    n_h = smd_pkg::SIDE_UPPER;
                    n_ucnt = r_ucnt + LW'(1);
                    n_utot = r_utot + TW'(r_ent[EW-1:SW]);
                    n_idx = r_ucnt + LW'(1);
                end
            end
            ST_SU_RD: begin
                h_ra = {r_h, r_idx >> 1};
                n_state = (r_idx <= LW'(1)) ? ST_SU_END : ST_SU_CMP;
            end
            // parent moves down into the hole when the entry beats it
            ST_SU_CMP: begin
                if (f_ahead(r_h, r_ent[EW-1:SW], top_val)) begin
                    h_we = 1'b1;  h_wdata = h_rd_a;
                    p_we = 1'b1;  p_waddr = h_rd_a[SW-1:0];
                    n_idx = r_idx >> 1;
                    n_state = ST_SU_RD;
                end else begin
                    n_state = ST_SU_END;
                end
            end
            ST_SU_END: begin
                if (r_down) begin
                    n_down = 1'b0;
                    n_state = ST_SD_RD;
                end else begin
                    h_we = 1'b1;  p_we = 1'b1;
                    n_state = r_ret;
                end
            end
            ST_SD_RD: begin
                h_ra = {r_h, kid_l[LW-1:0]};
                h_rb = {r_h, kid_r[LW-1:0]};
                n_state = (kid_l > {1'b0, cnt_h}) ? ST_SD_END : ST_SD_CMP;
            end
            // best child moves up into the hole
            ST_SD_CMP: begin
                if (best_moved) begin
                    h_we = 1'b1;  h_wdata = best_ent;
                    p_we = 1'b1;  p_waddr = best_ent[SW-1:0];
                    n_idx = best_idx;
                    n_state = ST_SD_RD;
                end else begin
                    n_state = ST_SD_END;
                end
            end
            ST_SD_END: begin
                h_we = 1'b1;  p_we = 1'b1;
                n_state = r_ret;
            end
            // move one top across when the halves are out of balance
            ST_REB: begin
                n_idx = LW'(1);  n_ret = ST_RBPUSH;
                if (r_ucnt > r_lcnt) begin
                    n_h = smd_pkg::SIDE_UPPER;  n_state = ST_RM_RD;
                end else if (r_lcnt > r_ucnt + LW'(1)) begin
                    n_h = smd_pkg::SIDE_LOWER;  n_state = ST_RM_RD;
                end else begin
                    n_state = ST_RBEND;
                end
            end
            ST_RM_RD: begin
                h_ra = {r_h, r_idx};
                h_rb = {r_h, cnt_h};
                n_state = ST_RM_DO;
            end
            // last entry fills the hole left by the removed one
            ST_RM_DO: begin
                n_rem = h_rd_a;
                if (r_h) begin
                    n_ucnt = r_ucnt - LW'(1);
                    n_utot = r_utot - TW'(h_rd_a[EW-1:SW]);
                end else begin
                    n_lcnt = r_lcnt - LW'(1);
                    n_ltot = r_ltot - TW'(h_rd_a[EW-1:SW]);
                end
                if (r_idx < cnt_h) begin
                    n_ent = h_rd_b;  n_down = 1'b1;
                    n_state = ST_SU_RD;
                end else begin
                    n_state = r_ret;
                end
            end
            ST_RBPUSH: begin
                n_h = ~r_h;  n_ent = r_rem;  n_down = 1'b0;  n_ret = ST_RBEND;
                n_state = ST_SU_RD;
                if (r_h) begin
                    n_lcnt = r_lcnt + LW'(1);
                    n_ltot = r_ltot + TW'(r_rem[EW-1:SW]);
                    n_idx = r_lcnt + LW'(1);
                end else begin
                    n_ucnt = r_ucnt + LW'(1);
                    n_utot = r_utot + TW'(r_rem[EW-1:SW]);
                    n_idx = r_ucnt + LW'(1);
                end
            end
            ST_RBEND: begin
                n_state = r_phase ? ST_IDLE : ST_POST;
            end
            ST_POST: begin
                n_wslot = (r_slot == SLOT_LAST) ? '0 : r_slot + SW'(1);
                n_fill = fill_inc;
                n_oldest = old_diff[LW] ? SW'(old_diff + AW'(WMAX)) : SW'(old_diff);
                n_state = (fill_inc >= len_eff) ? ST_OUT : ST_IDLE;
            end
            // result goes out once the output register is free
            ST_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_med = top_val;
                    n_cost = ((r_lcnt != r_ucnt) ? TW'(top_val) : '0) + r_utot - r_ltot;
                    n_fill = len_eff - LW'(1);
                    n_phase = 1'b1;  n_ret = ST_REB;
                    n_state = ST_RM_POS;
                end
            end
            ST_RM_POS: begin
                n_state = ST_RM_PSW;
            end
            ST_RM_PSW: begin
                n_h = p_rd[LW];
                n_idx = p_rd[LW-1:0];
                n_state = ST_RM_RD;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;  r_ret <= ST_IDLE;  r_len <= LW'(1);
            r_lcnt <= '0;  r_ucnt <= '0;  r_fill <= '0;
            r_ltot <= '0;  r_utot <= '0;  r_wslot <= '0;
            r_out_valid <= 1'b0;  r_phase <= 1'b0;  r_down <= 1'b0;
        end else begin
            r_state <= n_state;  r_ret <= n_ret;  r_len <= n_len;
            r_lcnt <= n_lcnt;  r_ucnt <= n_ucnt;  r_fill <= n_fill;
            r_ltot <= n_ltot;  r_utot <= n_utot;  r_wslot <= n_wslot;
            r_out_valid <= n_out_valid;  r_phase <= n_phase;  r_down <= n_down;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;  r_oldest <= n_oldest;
        r_ent <= n_ent;    r_rem <= n_rem;    r_idx <= n_idx;  r_h <= n_h;
        r_med <= n_med;    r_cost <= n_cost;
    end

    smd_store #(
        .WMAX (WMAX),
        .SB   (SB)
    ) u_store (
        .i_clk       (i_clk),
        .i_h_we      (h_we),
        .i_h_waddr   (h_waddr),
        .i_h_wdata   (h_wdata),
        .i_h_raddr_a (h_ra),
        .i_h_raddr_b (h_rb),
        .o_h_rdata_a (h_rd_a),
        .o_h_rdata_b (h_rd_b),
        .i_p_we      (p_we),
        .i_p_waddr   (p_waddr),
        .i_p_wdata   (p_wdata),
        .i_p_raddr   (r_oldest),
        .o_p_rdata   (p_rd)
    );

    assign o_in_stall       = (r_state != ST_IDLE) || i_cfg_valid;
    assign o_cfg_ready      = (r_state == ST_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_median         = r_med;
    assign o_deviation_cost = r_cost;

    // checks
    `SMD_ASSERT_SAME(a_idle_balance, r_state == ST_IDLE,
        r_lcnt == r_ucnt || r_lcnt == r_ucnt + LW'(1))
    `SMD_ASSERT_SAME(a_idle_fill, r_state == ST_IDLE, r_fill < len_eff)
    `SMD_ASSERT_NEXT(a_accept_starts, i_in_valid && !o_in_stall, r_state == ST_INS)
    `SMD_ASSERT_NEXT(a_out_waits, r_state == ST_OUT && r_out_valid && i_out_stall,
        r_state == ST_OUT && r_out_valid)

endmodule

`default_nettype wire
